// File: hdl/lap7_pkg.sv
// Shared types and constants of the seven-point 3-D Laplacian stencil core.
package lap7_pkg;

   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 23;
   localparam int DIM_FIELD_WIDTH   = 7;
   localparam int LAYER_FIELD_WIDTH = 11;
   localparam int COEF_WIDTH        = 20;
   localparam int CENTER_COEF_WIDTH = 23;
   localparam int RESULT_WIDTH      = 40;

   localparam logic [DIM_FIELD_WIDTH-1:0]   DIM_RESET         = 7'd64;
   localparam logic [LAYER_FIELD_WIDTH-1:0] LAYER_RESET       = 11'd64;
   localparam logic [COEF_WIDTH-1:0]        COEF_RESET        = 20'd4225;
   localparam logic [CENTER_COEF_WIDTH-1:0] CENTER_COEF_RESET = 23'd25350;

   localparam logic signed [63:0] RESULT_MAX = 64'sd549755813887;
   localparam logic signed [63:0] RESULT_MIN = -64'sd549755813888;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROW_COUNT   = 3'd0,
      CSR_COL_COUNT   = 3'd1,
      CSR_LAYER_COUNT = 3'd2,
      CSR_COEF_X      = 3'd3,
      CSR_COEF_Y      = 3'd4,
      CSR_COEF_Z      = 3'd5,
      CSR_COEF_CENTER = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_DRAIN  = 1'b1
   } cmd_type;

   // Shift control shared by every delay cell of the tap chain.
   typedef struct packed {
      logic advance;
      logic restart;
   } cell_ctrl_type;

endpackage

// File: hdl/laplacian_7point_stencil_3d_core.sv
// Top level of the streaming seven-point 3-D Laplacian stencil core.
//
// Voxels enter in raster order (row index fastest, then column, then layer) and
// flow down a chain of delay cells whose taps present the center voxel and its
// six neighbors together; the result of a voxel leaves once the voxel one plane
// ahead of it has entered, and after the last voxel of a volume one drain item
// per remaining result flushes the final plane. Neighbors outside the volume
// count as zero. The block takes one item per clock, sustained: every delay
// cell that uses its RAM ring does one RAM write and one RAM read per item,
// and the arithmetic is a four-stage pipeline behind it, followed by the
// output register. Output back-pressure only stops input once the pipeline
// and the output register are full. The delay RAMs need no clearing pass
// after reset: every tap that a result uses has been written in the current
// volume. Writing a dimension register restarts the volume; coefficient
// writes apply to every result that has not yet passed the product stage.
module laplacian_7point_stencil_3d_core
   import lap7_pkg::*;
#(
   parameter int MAX_DIM      = 64,
   parameter int MAX_LAYERS   = 1024,
   parameter int SAMPLE_WIDTH = 16,
   localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // input items
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [DATA_W-1:0]          req_tdata,   // [SAMPLE_WIDTH-1:0] sample_value
   input  logic [0:0]                 req_tuser,   // [0] cmd
   // result items
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RESULT_WIDTH-1:0]    rsp_tdata,   // [39:0] result_value
   output logic                       rsp_tlast,   // last_of_volume
   // register writes
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int LAY_W   = $clog2(MAX_LAYERS + 1);
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int LIDX_W  = $clog2(MAX_LAYERS);
   localparam int LENA_MAX = MAX_DIM * (MAX_DIM - 1);
   localparam int LENA_W  = $clog2(LENA_MAX + 1);
   localparam int LENB_MAX = MAX_DIM - 1;
   localparam int LENB_W  = $clog2(LENB_MAX + 1);
   localparam int PC_W    = CENTER_COEF_WIDTH + 1 + SW;
   localparam int PX_W    = COEF_WIDTH + 1 + SW + 1;
   localparam int RES_W   = SW + 26;
   localparam int WIDE_W  = (RES_W > RESULT_WIDTH + 1) ? RES_W : RESULT_WIDTH + 1;
   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(RESULT_MAX);
   localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(RESULT_MIN);

   typedef struct packed {
      logic xp_ok;
      logic xm_ok;
      logic yp_ok;
      logic ym_ok;
      logic zp_ok;
      logic zm_ok;
      logic last;
   } nbr_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_FIELD_WIDTH-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [LAY_W-1:0] clamp_layers(input logic [LAYER_FIELD_WIDTH-1:0] v);
      logic [LAY_W-1:0] r;
      if (v == '0) begin
         r = LAY_W'(1);
      end else if (32'(v) > 32'(MAX_LAYERS)) begin
         r = LAY_W'(MAX_LAYERS);
      end else begin
         r = LAY_W'(v);
      end
      return r;
   endfunction

   // Distance between the newest voxel and the column-ahead tap.
   function automatic logic [LENA_W-1:0] len_a(input logic [DIM_W-1:0] rows,
                                                input logic [DIM_W-1:0] cols);
      logic [2*DIM_W-1:0] p;
      p = rows * (cols - DIM_W'(1));
      return LENA_W'(p);
   endfunction

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0]             rows_ff, cols_ff;
   logic [LAY_W-1:0]             layers_ff;
   logic [COEF_WIDTH-1:0]        coef_x_ff, coef_y_ff, coef_z_ff;
   logic [CENTER_COEF_WIDTH-1:0] coef_c_ff;
   logic [LENA_W-1:0]            len_a_ff;
   logic [LENB_W-1:0]            len_b_ff;
   logic                         restart;

   // A dimension write restarts the volume.
   always_comb begin
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT, CSR_COL_COUNT, CSR_LAYER_COUNT: restart = 1'b1;
            default:                                       restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= clamp_dim(DIM_RESET);
         cols_ff   <= clamp_dim(DIM_RESET);
         layers_ff <= clamp_layers(LAYER_RESET);
         coef_x_ff <= COEF_RESET;
         coef_y_ff <= COEF_RESET;
         coef_z_ff <= COEF_RESET;
         coef_c_ff <= CENTER_COEF_RESET;
         len_a_ff  <= len_a(clamp_dim(DIM_RESET), clamp_dim(DIM_RESET));
         len_b_ff  <= LENB_W'(clamp_dim(DIM_RESET) - DIM_W'(1));
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               rows_ff  <= clamp_dim(csr_wdata[DIM_FIELD_WIDTH-1:0]);
               len_a_ff <= len_a(clamp_dim(csr_wdata[DIM_FIELD_WIDTH-1:0]), cols_ff);
               len_b_ff <= LENB_W'(clamp_dim(csr_wdata[DIM_FIELD_WIDTH-1:0]) - DIM_W'(1));
            end
            CSR_COL_COUNT: begin
               cols_ff  <= clamp_dim(csr_wdata[DIM_FIELD_WIDTH-1:0]);
               len_a_ff <= len_a(rows_ff, clamp_dim(csr_wdata[DIM_FIELD_WIDTH-1:0]));
            end
            CSR_LAYER_COUNT: layers_ff <= clamp_layers(csr_wdata[LAYER_FIELD_WIDTH-1:0]);
            CSR_COEF_X:      coef_x_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_Y:      coef_y_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_Z:      coef_z_ff <= csr_wdata[COEF_WIDTH-1:0];
            CSR_COEF_CENTER: coef_c_ff <= csr_wdata[CENTER_COEF_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline enables
   logic rsp_v_ff;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic en_out, en4, en3, en2, en1;
   logic pend_ff, pend_in;

   // Each stage moves when it is empty or the stage after it moves.
   assign en_out = !rsp_v_ff || rsp_tready;
   assign en4    = !s4_v_ff || en_out;
   assign en3    = !s3_v_ff || en4;
   assign en2    = !s2_v_ff || en3;
   assign en1    = !s1_v_ff || en2;

   // Taps may shift only once the last emitted window has been copied out.
   assign req_tready = !pend_ff || en1;

   // ---------------------------------------------------------------- positions
   logic              accept, is_drain, store, drain_go, advance, emit, take;
   logic [IDX_W-1:0]  in_i_ff, in_i_in, in_j_ff, in_j_in;
   logic [LIDX_W-1:0] in_k_ff, in_k_in;
   logic              in_full_ff, in_full_in;
   logic [IDX_W-1:0]  out_i_ff, out_i_in, out_j_ff, out_j_in;
   logic [LIDX_W-1:0] out_k_ff, out_k_in;
   logic              in_i_last, in_j_last, in_k_last;
   logic              out_i_last, out_j_last, out_k_last, out_last;

   assign accept   = req_tvalid && req_tready;
   assign is_drain = cmd_type'(req_tuser[0]) == CMD_DRAIN;
   // Drop samples past the end of the volume and drains before it is complete.
   assign store    = accept && !is_drain && !in_full_ff;
   assign drain_go = accept && is_drain && in_full_ff;
   assign advance  = store || drain_go;
   // A sample emits once the first plane plus one voxel is in.
   assign emit     = (store && (in_k_ff != '0)) || drain_go;
   assign take     = pend_ff && en1;

   assign in_i_last  = DIM_W'(in_i_ff) == rows_ff - DIM_W'(1);
   assign in_j_last  = DIM_W'(in_j_ff) == cols_ff - DIM_W'(1);
   assign in_k_last  = LAY_W'(in_k_ff) == layers_ff - LAY_W'(1);
   assign out_i_last = DIM_W'(out_i_ff) == rows_ff - DIM_W'(1);
   assign out_j_last = DIM_W'(out_j_ff) == cols_ff - DIM_W'(1);
   assign out_k_last = LAY_W'(out_k_ff) == layers_ff - LAY_W'(1);
   assign out_last   = out_i_last && out_j_last && out_k_last;

   always_comb begin
      in_i_in    = in_i_ff;
      in_j_in    = in_j_ff;
      in_k_in    = in_k_ff;
      in_full_in = in_full_ff;
      out_i_in   = out_i_ff;
      out_j_in   = out_j_ff;
      out_k_in   = out_k_ff;
      if (restart) begin
         in_i_in    = '0;
         in_j_in    = '0;
         in_k_in    = '0;
         in_full_in = 1'b0;
         out_i_in   = '0;
         out_j_in   = '0;
         out_k_in   = '0;
      end else begin
         if (store) begin
            if (in_i_last) begin
               in_i_in = '0;
               if (in_j_last) begin
                  in_j_in = '0;
                  if (in_k_last) begin
                     in_k_in    = '0;
                     in_full_in = 1'b1;
                  end else begin
                     in_k_in = in_k_ff + LIDX_W'(1);
                  end
               end else begin
                  in_j_in = in_j_ff + IDX_W'(1);
               end
            end else begin
               in_i_in = in_i_ff + IDX_W'(1);
            end
         end
         if (emit) begin
            if (out_last) begin
               // Volume done: start the next one from scratch.
               in_i_in    = '0;
               in_j_in    = '0;
               in_k_in    = '0;
               in_full_in = 1'b0;
               out_i_in   = '0;
               out_j_in   = '0;
               out_k_in   = '0;
            end else if (out_i_last) begin
               out_i_in = '0;
               if (out_j_last) begin
                  out_j_in = '0;
                  out_k_in = out_k_ff + LIDX_W'(1);
               end else begin
                  out_j_in = out_j_ff + IDX_W'(1);
               end
            end else begin
               out_i_in = out_i_ff + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (emit) begin
         pend_in = 1'b1;
      end else if (take) begin
         pend_in = 1'b0;
      end
   end

   nbr_type nbr_ff, nbr_in;

   always_comb begin
      nbr_in.xp_ok = !out_i_last;
      nbr_in.xm_ok = out_i_ff != '0;
      nbr_in.yp_ok = !out_j_last;
      nbr_in.ym_ok = out_j_ff != '0;
      nbr_in.zp_ok = !out_k_last;
      nbr_in.zm_ok = out_k_ff != '0;
      nbr_in.last  = out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_i_ff    <= '0;
         in_j_ff    <= '0;
         in_k_ff    <= '0;
         in_full_ff <= 1'b0;
         out_i_ff   <= '0;
         out_j_ff   <= '0;
         out_k_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         in_i_ff    <= in_i_in;
         in_j_ff    <= in_j_in;
         in_k_ff    <= in_k_in;
         in_full_ff <= in_full_in;
         out_i_ff   <= out_i_in;
         out_j_ff   <= out_j_in;
         out_k_ff   <= out_k_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         nbr_ff <= nbr_in;
      end
   end

   // ---------------------------------------------------------------- tap chain
   // Newest voxel N enters zp; the cells then hand it down so that the taps
   // hold N-plane+rows, N-plane+1, N-plane (center), N-plane-1, N-plane-rows
   // and N-2*plane.
   cell_ctrl_type     cell_ctrl;
   logic signed [SW-1:0] zp_ff, yp, xp, center_ff, xm_ff, ym, zm;

   assign cell_ctrl = '{advance: advance, restart: restart};

   always_ff @(posedge clock) begin
      if (advance) begin
         zp_ff     <= req_tdata[SW-1:0];
         center_ff <= xp;
         xm_ff     <= center_ff;
      end
   end

   lap7_cell #(.WIDTH(SW), .MAX_LEN(LENA_MAX)) u_cell_col_ahead (
      .clock (clock), .reset (reset), .ctrl (cell_ctrl),
      .len (len_a_ff), .din (zp_ff), .dout (yp)
   );

   lap7_cell #(.WIDTH(SW), .MAX_LEN(LENB_MAX)) u_cell_row_ahead (
      .clock (clock), .reset (reset), .ctrl (cell_ctrl),
      .len (len_b_ff), .din (yp), .dout (xp)
   );

   lap7_cell #(.WIDTH(SW), .MAX_LEN(LENB_MAX)) u_cell_row_behind (
      .clock (clock), .reset (reset), .ctrl (cell_ctrl),
      .len (len_b_ff), .din (xm_ff), .dout (ym)
   );

   lap7_cell #(.WIDTH(SW), .MAX_LEN(LENA_MAX)) u_cell_col_behind (
      .clock (clock), .reset (reset), .ctrl (cell_ctrl),
      .len (len_a_ff), .din (ym), .dout (zm)
   );

   // ---------------------------------------------------------------- stage 1: pair sums
   logic signed [SW-1:0] xp_m, xm_m, yp_m, ym_m, zp_m, zm_m;
   logic signed [SW-1:0] c1_ff;
   logic signed [SW:0]   sx1_ff, sy1_ff, sz1_ff;
   logic                 last1_ff;

   // Zero the neighbors that fall outside the volume.
   assign xp_m = nbr_ff.xp_ok ? xp    : '0;
   assign xm_m = nbr_ff.xm_ok ? xm_ff : '0;
   assign yp_m = nbr_ff.yp_ok ? yp    : '0;
   assign ym_m = nbr_ff.ym_ok ? ym    : '0;
   assign zp_m = nbr_ff.zp_ok ? zp_ff : '0;
   assign zm_m = nbr_ff.zm_ok ? zm    : '0;

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff    <= center_ff;
         sx1_ff   <= (SW + 1)'(xp_m) + (SW + 1)'(xm_m);
         sy1_ff   <= (SW + 1)'(yp_m) + (SW + 1)'(ym_m);
         sz1_ff   <= (SW + 1)'(zp_m) + (SW + 1)'(zm_m);
         last1_ff <= nbr_ff.last;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic signed [PC_W-1:0] pc2_ff;
   logic signed [PX_W-1:0] px2_ff, py2_ff, pz2_ff;
   logic                   last2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         pc2_ff   <= $signed({1'b0, coef_c_ff}) * c1_ff;
         px2_ff   <= $signed({1'b0, coef_x_ff}) * sx1_ff;
         py2_ff   <= $signed({1'b0, coef_y_ff}) * sy1_ff;
         pz2_ff   <= $signed({1'b0, coef_z_ff}) * sz1_ff;
         last2_ff <= last1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3 and 4: sum
   logic signed [RES_W-1:0] a3_ff, b3_ff, r4_ff;
   logic                    last3_ff, last4_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         a3_ff    <= RES_W'(pc2_ff) - RES_W'(pz2_ff);
         b3_ff    <= RES_W'(px2_ff) + RES_W'(py2_ff);
         last3_ff <= last2_ff;
      end
      if (en4) begin
         r4_ff    <= a3_ff - b3_ff;
         last4_ff <= last3_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   logic signed [WIDE_W-1:0]  r_wide;
   logic [RESULT_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff;

   // Clip to the signed result range; only wide samples can reach it.
   assign r_wide = WIDE_W'(r4_ff);

   always_comb begin
      if (r_wide > SAT_HI) begin
         rsp_data_in = RESULT_WIDTH'(SAT_HI);
      end else if (r_wide < SAT_LO) begin
         rsp_data_in = RESULT_WIDTH'(SAT_LO);
      end else begin
         rsp_data_in = RESULT_WIDTH'(r_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= take;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en4) begin
            s4_v_ff <= s3_v_ff;
         end
         if (en_out) begin
            rsp_v_ff <= s4_v_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hdl/lap7_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
module lap7_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lap7_cell.sv
// Programmable delay cell of the stencil tap chain (bypass, register or RAM ring).
module lap7_cell
   import lap7_pkg::*;
#(
   parameter int WIDTH   = 16,
   parameter int MAX_LEN = 64,
   localparam int LEN_W  = $clog2(MAX_LEN + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [LEN_W-1:0] len,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   // A delay of len advances: the output register adds one, the ring the rest.
   localparam int DEPTH = (MAX_LEN > 2) ? MAX_LEN - 1 : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [WIDTH-1:0] hold_ff;
   logic [WIDTH-1:0] ram_rdata;
   logic             use_ram;
   logic             wrap;

   assign use_ram = len > LEN_W'(1);
   assign wrap    = ({1'b0, LEN_W'(ptr_ff)} + (LEN_W + 1)'(2)) >= {1'b0, len};

   always_comb begin
      ptr_in = ptr_ff;
      if (ctrl.restart) begin
         ptr_in = '0;
      end else if (ctrl.advance && use_ram) begin
         ptr_in = wrap ? '0 : ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         hold_ff <= din;
      end
   end

   lap7_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctrl.advance && use_ram),
      .wr_addr (ptr_ff),
      .wr_data (din),
      .rd_en   (ctrl.advance && use_ram),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (len == '0) begin
         dout = din;
      end else if (len == LEN_W'(1)) begin
         dout = hold_ff;
      end else begin
         dout = ram_rdata;
      end
   end

endmodule

// File: hdl/lap7_checker.sv
// Port-level checks of the stencil core, bound to its top level.
module lap7_checker
   import lap7_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RESULT_WIDTH-1:0] rsp_tdata,
   input logic                    rsp_tlast
);

   // Items taken minus results delivered.
   logic [31:0] balance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff <= '0;
      end else begin
         balance_ff <= balance_ff + 32'(req_tvalid && req_tready)
                                  - 32'(rsp_tvalid && rsp_tready);
      end
   end

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A valid result needs more items taken than results delivered so far.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> balance_ff != 32'd0)
      else $error("result without a causing item");

   // With the output empty the pipeline has room, so input must be ready.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // Reset drops any pending result.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind laplacian_7point_stencil_3d_core lap7_checker u_lap7_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/tb_laplacian_7point_stencil_3d_core.sv
// Self-checking testbench of the streaming seven-point 3-D Laplacian stencil core.
`timescale 1ns / 1ps

module tb_laplacian_7point_stencil_3d_core;
   import lap7_pkg::*;

   localparam int DIM_MAX       = 64;
   localparam int LAYER_MAX     = 1024;
   localparam int WINDOW_DEPTH  = 2 * DIM_MAX * DIM_MAX + 1;
   localparam int IDLE_PERCENT  = 36;
   // margin for the pipeline to settle after the last result is out
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_ITEMS  = 230;
   localparam longint TIMEOUT_NS = 2_000_000;

   // register index that decodes to nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct {
      logic [RESULT_WIDTH-1:0] value;
      logic                    last;
   } stencil_result_t;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata  = '0;   // [15:0] sample_value
   logic [0:0]                 req_tuser  = '0;   // [0] cmd
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RESULT_WIDTH-1:0]    rsp_tdata;         // [39:0] result_value
   logic                       rsp_tlast;         // last_of_volume
   logic                       csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   // Shadow copy of the core's registers and voxel window.
   logic [DIM_FIELD_WIDTH-1:0]   row_field;
   logic [DIM_FIELD_WIDTH-1:0]   col_field;
   logic [LAYER_FIELD_WIDTH-1:0] layer_field;
   logic [COEF_WIDTH-1:0]        weight_x;
   logic [COEF_WIDTH-1:0]        weight_y;
   logic [COEF_WIDTH-1:0]        weight_z;
   logic [CENTER_COEF_WIDTH-1:0] weight_center;
   logic signed [15:0]           voxel_window [WINDOW_DEPTH];
   int unsigned                  voxels_in;
   int unsigned                  results_out;

   stencil_result_t pending_stencil_results[$];
   stencil_result_t oldest_result;

   bit steady_stream = 1'b0;   // when set, neither side idles
   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int volumes_checked = 0;

   laplacian_7point_stencil_3d_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Stencil prediction
   // ---------------------------------------------------------------------

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic longint window_at(int unsigned pos);
      return longint'(voxel_window[pos % WINDOW_DEPTH]);
   endfunction

   // Compute the result of the next voxel in line and advance the output side.
   task automatic emit_stencil(input int unsigned rows, input int unsigned cols,
                               input int unsigned layers);
      int unsigned     plane;
      int unsigned     o;
      int unsigned     i;
      int unsigned     j;
      int unsigned     k;
      longint          neighbors;
      longint          res;
      stencil_result_t r;
      plane = rows * cols;
      o = results_out;
      i = o % rows;
      j = (o / rows) % cols;
      k = o / plane;
      neighbors = 0;
      // drop every neighbor that falls outside the volume
      if (i + 1 < rows)   neighbors += longint'(weight_x) * window_at(o + 1);
      if (i > 0)          neighbors += longint'(weight_x) * window_at(o - 1);
      if (j + 1 < cols)   neighbors += longint'(weight_y) * window_at(o + rows);
      if (j > 0)          neighbors += longint'(weight_y) * window_at(o - rows);
      if (k + 1 < layers) neighbors += longint'(weight_z) * window_at(o + plane);
      if (k > 0)          neighbors += longint'(weight_z) * window_at(o - plane);
      res = longint'(weight_center) * window_at(o) - neighbors;
      if (res > RESULT_MAX) res = RESULT_MAX;
      if (res < RESULT_MIN) res = RESULT_MIN;
      r.value = res[RESULT_WIDTH-1:0];
      r.last  = (o + 1 == plane * layers);
      pending_stencil_results.push_back(r);
      results_out = o + 1;
      // close the volume: both positions wrap for the next one
      if (results_out == plane * layers) begin
         results_out = 0;
         voxels_in   = 0;
      end
   endtask

   // Update the shadow state for one accepted item.
   task automatic predict_stencil(input cmd_type cmd, input logic [15:0] sample);
      int unsigned rows;
      int unsigned cols;
      int unsigned layers;
      int unsigned plane;
      int unsigned total;
      rows   = clamp_dim(row_field, DIM_MAX);
      cols   = clamp_dim(col_field, DIM_MAX);
      layers = clamp_dim(layer_field, LAYER_MAX);
      plane  = rows * cols;
      total  = plane * layers;
      if (cmd == CMD_SAMPLE) begin
         // discard a sample once the whole volume is in
         if (voxels_in < total) begin
            voxel_window[voxels_in % WINDOW_DEPTH] = sample;
            voxels_in++;
            if (voxels_in > plane) emit_stencil(rows, cols, layers);
         end
      end else if (voxels_in == total && results_out < total) begin
         emit_stencil(rows, cols, layers);
      end
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Send one item; keep tvalid high when the next item follows at once.
   task automatic send_item(input cmd_type cmd, input logic [15:0] sample);
      if (!steady_stream && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PERCENT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_stencil(cmd, sample);
   endtask

   // Drive one register write; the caller lowers csr_we after the last one.
   task automatic csr_cycle(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_ROW_COUNT: begin
            row_field = value[DIM_FIELD_WIDTH-1:0];
            voxels_in = 0;
            results_out = 0;
         end
         CSR_COL_COUNT: begin
            col_field = value[DIM_FIELD_WIDTH-1:0];
            voxels_in = 0;
            results_out = 0;
         end
         CSR_LAYER_COUNT: begin
            layer_field = value[LAYER_FIELD_WIDTH-1:0];
            voxels_in = 0;
            results_out = 0;
         end
         CSR_COEF_X:      weight_x      = value[COEF_WIDTH-1:0];
         CSR_COEF_Y:      weight_y      = value[COEF_WIDTH-1:0];
         CSR_COEF_Z:      weight_z      = value[COEF_WIDTH-1:0];
         CSR_COEF_CENTER: weight_center = value[CENTER_COEF_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Load weights (optionally) and then the three dimensions, which restart the volume.
   task automatic program_volume(input bit with_weights,
                                 input int unsigned rows, input int unsigned cols,
                                 input int unsigned layers,
                                 input logic [COEF_WIDTH-1:0] wx,
                                 input logic [COEF_WIDTH-1:0] wy,
                                 input logic [COEF_WIDTH-1:0] wz,
                                 input logic [CENTER_COEF_WIDTH-1:0] wc);
      if (with_weights) begin
         csr_cycle(CSR_COEF_X, wx);
         csr_cycle(CSR_COEF_Y, wy);
         csr_cycle(CSR_COEF_Z, wz);
         csr_cycle(CSR_COEF_CENTER, wc);
      end
      csr_cycle(CSR_ROW_COUNT, rows);
      csr_cycle(CSR_COL_COUNT, cols);
      csr_cycle(CSR_LAYER_COUNT, layers);
      csr_we <= 1'b0;
   endtask

   // Hold input until every expected result is out, then let the pipeline settle.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (pending_stencil_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CENTER_COEF_WIDTH-1:0] random_weight(input int width);
      logic [CENTER_COEF_WIDTH-1:0] mask;
      mask = (23'd1 << width) - 23'd1;
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return mask;
         default: return CENTER_COEF_WIDTH'($urandom) & mask;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and output back-pressure
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= steady_stream || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stencil_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %0d last %0b", $time,
                     $signed(rsp_tdata), rsp_tlast);
         end else begin
            oldest_result = pending_stencil_results.pop_front();
            results_checked++;
            if (rsp_tdata !== oldest_result.value) begin
               errors++;
               $display("%0t: result_value expected %0d actual %0d", $time,
                        $signed(oldest_result.value), $signed(rsp_tdata));
            end
            if (rsp_tlast !== oldest_result.last) begin
               errors++;
               $display("%0t: last_of_volume expected %0b actual %0b", $time,
                        oldest_result.last, rsp_tlast);
            end
            if (oldest_result.last) volumes_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Small 2x2x2 volume at the reset weights; sample extremes, a drain before
   // the volume is complete, a sample during the drain phase, a drain after the end.
   task automatic test_reset_weights();
      program_volume(1'b0, 2, 2, 2, '0, '0, '0, '0);
      send_item(CMD_DRAIN, 16'h1234);
      send_item(CMD_SAMPLE, 16'h8000);
      send_item(CMD_SAMPLE, 16'h7FFF);
      send_item(CMD_SAMPLE, 16'h0000);
      send_item(CMD_SAMPLE, 16'hFFFF);
      send_item(CMD_SAMPLE, 16'h0100);
      send_item(CMD_SAMPLE, 16'hFF00);
      send_item(CMD_SAMPLE, 16'h5555);
      send_item(CMD_SAMPLE, 16'hAAAA);
      send_item(CMD_SAMPLE, 16'h4321);   // volume full: drop it
      repeat (4) send_item(CMD_DRAIN, 16'hFFFF);
      send_item(CMD_DRAIN, 16'h0000);    // next volume still empty: ignored
      wait_results_done();
   endtask

   // Single layer with zero row and layer counts (used as one) and all weights
   // at full scale; an unused register index is written mid-volume.
   task automatic test_single_layer_full_weights();
      program_volume(1'b1, 0, 3, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 23'h7FFFFF);
      send_item(CMD_SAMPLE, 16'h7FFF);
      send_item(CMD_SAMPLE, 16'h8000);
      send_item(CMD_SAMPLE, 16'h7FFF);
      wait_results_done();
      csr_cycle(CSR_UNUSED_INDEX, '1);
      csr_we <= 1'b0;
      repeat (3) send_item(CMD_DRAIN, 16'h0000);
      wait_results_done();
   endtask

   // Oversized dimension fields clamp to the bounds; a few samples go in and
   // the next dimension write must restart the volume.
   task automatic test_clamped_restart();
      program_volume(1'b1, 127, 127, 2047, 20'd0, 20'd0, 20'd0, 23'd1);
      repeat (5) send_item(CMD_SAMPLE, random_sample());
      wait_results_done();
   endtask

   // A full-length row (clamped from 127) over two layers, streamed without
   // gaps; hold input after 100 samples until every result is out.
   task automatic test_full_row_stream();
      program_volume(1'b1, 127, 1, 2, random_weight(COEF_WIDTH),
                     random_weight(COEF_WIDTH), random_weight(COEF_WIDTH),
                     random_weight(CENTER_COEF_WIDTH));
      steady_stream = 1'b1;
      for (int n = 0; n < 2 * DIM_MAX; n++) begin
         if (n == 100) wait_results_done();
         send_item(CMD_SAMPLE, random_sample());
      end
      repeat (DIM_MAX) send_item(CMD_DRAIN, random_sample());
      wait_results_done();
      steady_stream = 1'b0;
   endtask

   // Random small volumes and weights; mostly complete sequences, some cut
   // short, with stray drains and surplus samples mixed in.
   task automatic test_random_volumes();
      int unsigned rows;
      int unsigned cols;
      int unsigned layers;
      int unsigned total;
      int unsigned steps;
      int unsigned cut;
      int          random_items;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         rows   = $urandom_range(0, 6);
         cols   = $urandom_range(0, 5);
         layers = $urandom_range(0, 4);
         program_volume(1'b1, rows, cols, layers, random_weight(COEF_WIDTH),
                        random_weight(COEF_WIDTH), random_weight(COEF_WIDTH),
                        random_weight(CENTER_COEF_WIDTH));
         total = clamp_dim(rows, DIM_MAX) * clamp_dim(cols, DIM_MAX)
                 * clamp_dim(layers, LAYER_MAX);
         steps = total + clamp_dim(rows, DIM_MAX) * clamp_dim(cols, DIM_MAX);
         cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, steps - 1) : steps;
         for (int unsigned n = 0; n < cut; n++) begin
            // stray item of the wrong kind for this phase: the core drops it
            if ($urandom_range(0, 19) == 0)
               send_item(n < total ? CMD_DRAIN : CMD_SAMPLE, random_sample());
            send_item(n < total ? CMD_SAMPLE : CMD_DRAIN, random_sample());
            random_items++;
         end
         wait_results_done();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      row_field     = DIM_RESET;
      col_field     = DIM_RESET;
      layer_field   = LAYER_RESET;
      weight_x      = COEF_RESET;
      weight_y      = COEF_RESET;
      weight_z      = COEF_RESET;
      weight_center = CENTER_COEF_RESET;
      foreach (voxel_window[n]) voxel_window[n] = '0;
      voxels_in   = 0;
      results_out = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_weights();
      test_single_layer_full_weights();
      test_clamped_restart();
      test_full_row_stream();
      test_random_volumes();

      wait_results_done();
      $display("Sent %0d items over reset, clamped, single-layer and random volumes;",
               items_sent);
      $display("checked %0d results closing %0d volumes, %0d errors.",
               results_checked, volumes_checked, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Timed out with %0d results outstanding", pending_stencil_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
